[rtl/utf8_stream_decoder_unit_assert.svh]
// Assertion macros shared by the decoder RTL
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, ignored during reset
`define UTF8DEC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utf8 decoder assertion failed");

// next-cycle implication
`define UTF8DEC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utf8 decoder assertion failed");

`endif

[rtl/utf8dec_pkg.sv]
// Shared types, constants and byte helpers for the UTF-8 stream decoder
package utf8dec_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned CNT_W  = 3;   // holds 0..4 bytes in the scan buffer

   localparam logic [CP_W-1:0]   REPL_CHAR   = 21'h00FFFD;
   localparam logic [CP_W-1:0]   MAX_CP      = 21'h10FFFF;
   localparam logic [9:0]        SURR_TOP    = 10'h01B;  // code_point[20:11] of D800..DFFF

   localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hF4;
   localparam logic [BYTE_W-1:0] LEAD_ED     = 8'hED;
   localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;
   localparam logic [BYTE_W-1:0] E0_MIN_2ND  = 8'hA0;
   localparam logic [BYTE_W-1:0] ED_MAX_2ND  = 8'h9F;
   localparam logic [BYTE_W-1:0] F0_MIN_2ND  = 8'h90;
   localparam logic [BYTE_W-1:0] F4_MAX_2ND  = 8'h8F;

   localparam logic              CMD_DATA    = 1'b0;
   localparam logic              CMD_FLUSH   = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;   // take the accepted request into the buffer
      logic step;   // emit one result and drop its bytes
   } cmd_type;

   typedef struct packed {
      logic stop_now;   // nothing to emit for the buffered bytes
      logic stop_next;  // the result being formed is the last of the run
      logic out_free;   // result register can take a new result
   } status_type;

   // expected sequence length from the lead byte; invalid leads count as 1
   function automatic logic [CNT_W-1:0] lead_width(input logic [BYTE_W-1:0] b);
      logic [CNT_W-1:0] w;
      if (!b[7])                              w = 3'd1;
      else if (b >= LEAD2_LO && b <= LEAD2_HI) w = 3'd2;
      else if (b >= LEAD3_LO && b <= LEAD3_HI) w = 3'd3;
      else if (b >= LEAD4_LO && b <= LEAD4_HI) w = 3'd4;
      else                                     w = 3'd1;
      return w;
   endfunction

   function automatic logic is_cont(input logic [BYTE_W-1:0] b);
      return (b & CONT_MASK) == CONT_TAG;
   endfunction

endpackage

[rtl/utf8dec_ctrl.sv]
// Controller: request intake and result sequencing for the UTF-8 decoder
module utf8dec_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  utf8dec_pkg::status_type sts,
   output utf8dec_pkg::cmd_type    cmd
);
   import utf8dec_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.stop_now) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.step = 1'b1;
               if (sts.stop_next) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/utf8dec_datapath.sv]
// Datapath: byte buffer, sequence check and decode, result register
module utf8dec_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  utf8dec_pkg::cmd_type              cmd,
   output utf8dec_pkg::status_type           sts,
   input  logic                              req_command,
   input  logic [utf8dec_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [utf8dec_pkg::CP_W-1:0]      rsp_code_point,
   output logic                              rsp_replaced,
   output logic                              rsp_last_of_run
);
   import utf8dec_pkg::*;

   // buffer: oldest byte in entry 0; only entries below cnt_ff are meaningful
   logic [BYTE_W-1:0] buf_ff [4];
   logic [BYTE_W-1:0] buf_in [4];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              flush_ff, flush_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]   cp_ff, cp_in;
   logic              rep_ff, rep_in;
   logic              last_ff, last_in;

   logic [BYTE_W-1:0] lead, second, nxt;
   logic [CNT_W-1:0]  width, drop, remain, sh;
   logic              bad_lead, short_seq, conts_ok, range_ok, good;
   logic [CP_W-1:0]   decoded;

   always_comb begin
      lead      = buf_ff[0];
      second    = buf_ff[1];
      width     = lead_width(lead);
      bad_lead  = lead[7] && (width == 3'd1);
      short_seq = width > cnt_ff;

      conts_ok = (width < 3'd2 || is_cont(buf_ff[1]))
              && (width < 3'd3 || is_cont(buf_ff[2]))
              && (width < 3'd4 || is_cont(buf_ff[3]));
      // overlong, surrogate and beyond-U+10FFFF forms show in the second byte
      range_ok = !(lead == LEAD3_LO && second < E0_MIN_2ND)
              && !(lead == LEAD_ED  && second > ED_MAX_2ND)
              && !(lead == LEAD4_LO && second < F0_MIN_2ND)
              && !(lead == LEAD4_HI && second > F4_MAX_2ND);
      good     = !bad_lead && !short_seq && conts_ok && range_ok;

      drop   = good ? width : 3'd1;
      remain = cnt_ff - drop;

      case (drop)
         3'd1:    nxt = buf_ff[1];
         3'd2:    nxt = buf_ff[2];
         3'd3:    nxt = buf_ff[3];
         default: nxt = buf_ff[0];
      endcase

      case (width)
         3'd2:    decoded = {10'd0, lead[4:0], buf_ff[1][5:0]};
         3'd3:    decoded = {5'd0, lead[3:0], buf_ff[1][5:0], buf_ff[2][5:0]};
         3'd4:    decoded = {lead[2:0], buf_ff[1][5:0], buf_ff[2][5:0], buf_ff[3][5:0]};
         default: decoded = {13'd0, lead};
      endcase

      sts.stop_now  = (cnt_ff == 3'd0) || (!flush_ff && short_seq);
      sts.stop_next = (remain == 3'd0)
                   || (!flush_ff && (lead_width(nxt) > remain));
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      sh       = '0;
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      flush_in = flush_ff;
      if (cmd.load) begin
         flush_in = req_command;
         if (req_command == CMD_DATA) begin
            buf_in[cnt_ff[1:0]] = req_data_byte;
            cnt_in              = cnt_ff + 3'd1;
         end
      end else if (cmd.step) begin
         for (int i = 0; i < 4; i++) begin
            sh = CNT_W'(i) + drop;
            if (sh < 3'd4) begin
               buf_in[i] = buf_ff[sh[1:0]];
            end
         end
         cnt_in = remain;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      cp_in        = cp_ff;
      rep_in       = rep_ff;
      last_in      = last_ff;
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
         cp_in        = good ? decoded : REPL_CHAR;
         rep_in       = !good;
         last_in      = sts.stop_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      cp_ff   <= cp_in;
      rep_ff  <= rep_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_replaced    = rep_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[rtl/utf8_stream_decoder_unit.sv]
// Top level of the UTF-8 stream decoder: controller, datapath and checks
// Usage:
//   req channel: one request per byte (req_command = data) or a flush request
//   (req_command = flush) at timeout or end of input. Held bytes of an
//   unfinished sequence (up to three) are kept between requests.
//   rsp channel: decoded scalar values in order; U+FFFD with rsp_replaced set
//   for malformed input; rsp_last_of_run marks the final result of a request.
//   A request may give no result (incomplete sequence, or flush when empty).
// Timing:
//   A request is taken into the byte buffer, then the shared check/decode
//   step runs once per result, each step waiting while the result register
//   is not free. The load registers the byte into the buffer; the first step
//   then writes the first result into the result register.
// Reset: synchronous, active high; clears held-byte count and result valid.
// Stall: while a held result waits on rsp_ready, the result register holds and
//   the step waits; req_ready stays low until the request's last result is formed.
module utf8_stream_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [utf8dec_pkg::BYTE_W-1:0]     req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [utf8dec_pkg::CP_W-1:0]       rsp_code_point,
   output logic                               rsp_replaced,
   output logic                               rsp_last_of_run
);
   import utf8dec_pkg::*;

   cmd_type    cmd;
   status_type sts;

   utf8dec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   utf8dec_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_replaced    (rsp_replaced),
      .rsp_last_of_run (rsp_last_of_run)
   );

`include "utf8_stream_decoder_unit_assert.svh"

   `UTF8DEC_ASSERT_IMP(a_repl_value, rsp_valid && rsp_replaced, rsp_code_point == REPL_CHAR)
   `UTF8DEC_ASSERT_IMP(a_scalar_value, rsp_valid && !rsp_replaced,
      rsp_code_point <= MAX_CP && rsp_code_point[20:11] != SURR_TOP)
   `UTF8DEC_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)
   `UTF8DEC_ASSERT_IMP(a_step_not_idle, req_ready, !cmd.step)

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the UTF-8 stream decoder unit
`timescale 1ns / 100ps

module testbench;
   import utf8dec_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_REQS = 235;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] data;
   } byte_req_t;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            replaced;
      logic            last_of_run;
   } char_result_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_command = CMD_DATA;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CP_W-1:0]     rsp_code_point;
   logic                rsp_replaced;
   logic                rsp_last_of_run;

   byte_req_t           byte_reqs [$];
   char_result_t        pending_chars [$];
   logic [2:0][7:0]     held_bytes = '0;
   int unsigned         held_count = 0;
   int                  total_reqs = 0;
   int                  accepted_reqs = 0;
   int                  accepted_flushes = 0;
   int                  chars_seen = 0;
   int                  repl_seen = 0;
   int                  error_count = 0;
   int                  stall_cycles = 0;

   // both sides run flat out for this stretch of requests
   wire quiet_run = (accepted_reqs >= 110) && (accepted_reqs < 170);

   utf8_stream_decoder_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_replaced    (rsp_replaced),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic queue_request(input logic cmd, input logic [BYTE_W-1:0] data);
      byte_req_t r;
      r.cmd  = cmd;
      r.data = data;
      byte_reqs.push_back(r);
   endtask

   task automatic queue_flush();
      queue_request(CMD_FLUSH, 8'($urandom_range(255)));
   endtask

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   function automatic int unsigned seq_len(input logic [7:0] lead);
      if (!lead[7]) return 1;
      if (lead >= LEAD2_LO && lead <= LEAD2_HI) return 2;
      if (lead >= LEAD3_LO && lead <= LEAD3_HI) return 3;
      if (lead >= LEAD4_LO && lead <= LEAD4_HI) return 4;
      return 1;
   endfunction

   // window holds a complete candidate of width w, oldest byte in [0]
   function automatic logic well_formed(input logic [3:0][7:0] s, input int unsigned w);
      logic ok;
      ok = 1'b1;
      if (w == 1) return !s[0][7];
      for (int i = 1; i < w; i++)
         if ((s[i] & CONT_MASK) != CONT_TAG) ok = 1'b0;
      if (s[0] == LEAD3_LO && s[1] < E0_MIN_2ND) ok = 1'b0;   // overlong
      if (s[0] == LEAD_ED && s[1] > ED_MAX_2ND) ok = 1'b0;    // surrogate
      if (s[0] == LEAD4_LO && s[1] < F0_MIN_2ND) ok = 1'b0;   // overlong
      if (s[0] == LEAD4_HI && s[1] > F4_MAX_2ND) ok = 1'b0;   // above U+10FFFF
      return ok;
   endfunction

   // scan held bytes plus the new request, queue the characters it yields
   task automatic predict_decode(input logic cmd, input logic [BYTE_W-1:0] data);
      logic [3:0][7:0] scan;
      logic            is_flush;
      int unsigned     n;
      int unsigned     w;
      int unsigned     drop;
      char_result_t    run [$];
      char_result_t    r;
      scan = {8'h00, held_bytes};
      n = held_count;
      is_flush = (cmd == CMD_FLUSH);
      if (!is_flush) begin
         scan[n] = data;
         n++;
      end
      while (n > 0 && run.size() < 4) begin
         w = seq_len(scan[0]);
         drop = 1;
         r.code_point = REPL_CHAR;
         r.replaced = 1'b1;
         r.last_of_run = 1'b0;
         if (w > n) begin
            if (!is_flush) break;
         end else if (well_formed(scan, w)) begin
            case (w)
               1: r.code_point = {14'd0, scan[0][6:0]};
               2: r.code_point = {10'd0, scan[0][4:0], scan[1][5:0]};
               3: r.code_point = {5'd0, scan[0][3:0], scan[1][5:0], scan[2][5:0]};
               default: r.code_point = {scan[0][2:0], scan[1][5:0], scan[2][5:0],
                                        scan[3][5:0]};
            endcase
            r.replaced = 1'b0;
            drop = w;
         end
         run.push_back(r);
         scan = scan >> (8 * drop);
         n -= drop;
      end
      held_bytes = scan[2:0];
      held_count = n;
      if (run.size() != 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i]) pending_chars.push_back(run[i]);
   endtask

   always @(posedge clock) begin : drive_req
      byte_req_t nxt_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_decode(req_command, req_data_byte);
            accepted_reqs++;
            if (req_command == CMD_FLUSH) accepted_flushes++;
         end
         if (!req_valid || req_ready) begin
            if (byte_reqs.size() != 0 && (quiet_run || $urandom_range(99) >= 12)) begin
               nxt_req = byte_reqs.pop_front();
               req_valid <= 1'b1;
               req_command <= nxt_req.cmd;
               req_data_byte <= nxt_req.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      char_result_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_run || ($urandom_range(99) >= 12);
         if (rsp_valid && rsp_ready) begin
            chars_seen++;
            if (rsp_replaced) repl_seen++;
            if (pending_chars.size() == 0) begin
               flag_mismatch($sformatf("unexpected character U+%06h", rsp_code_point));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_code_point !== want.code_point)
                  flag_mismatch($sformatf("code point U+%06h, wanted U+%06h",
                                          rsp_code_point, want.code_point));
               if (rsp_replaced !== want.replaced)
                  flag_mismatch($sformatf("replaced %b, wanted %b on U+%06h",
                                          rsp_replaced, want.replaced, want.code_point));
               if (rsp_last_of_run !== want.last_of_run)
                  flag_mismatch($sformatf("last_of_run %b, wanted %b on U+%06h",
                                          rsp_last_of_run, want.last_of_run,
                                          want.code_point));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d characters outstanding",
                  stall_cycles, pending_chars.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : run_stimulus
      logic [3:0][7:0] seq;
      logic [CP_W-1:0] cp;
      int unsigned     len;
      int unsigned     pick;
      int unsigned     dmg;

      queue_request(CMD_DATA, 8'h00);
      queue_request(CMD_DATA, 8'h7F);
      queue_request(CMD_DATA, 8'hFF);           // invalid lead
      queue_flush();                            // nothing held
      // bad continuation is only judged once the width is complete
      queue_request(CMD_DATA, 8'hE2);
      queue_request(CMD_DATA, 8'h41);
      queue_request(CMD_DATA, 8'h42);
      // overlong four-byte form: four characters from one byte
      queue_request(CMD_DATA, LEAD4_LO);
      queue_request(CMD_DATA, 8'h80);
      queue_request(CMD_DATA, 8'h80);
      queue_request(CMD_DATA, 8'h41);
      queue_request(CMD_DATA, LEAD4_HI);        // U+10FFFF
      queue_request(CMD_DATA, F4_MAX_2ND);
      queue_request(CMD_DATA, 8'hBF);
      queue_request(CMD_DATA, 8'hBF);
      queue_request(CMD_DATA, LEAD_ED);         // surrogate
      queue_request(CMD_DATA, 8'hA0);
      queue_request(CMD_DATA, 8'h80);
      queue_request(CMD_DATA, 8'hE2);           // short sequences cut by flush
      queue_request(CMD_DATA, 8'h82);
      queue_flush();
      queue_request(CMD_DATA, LEAD4_LO);
      queue_request(CMD_DATA, F0_MIN_2ND);
      queue_request(CMD_DATA, 8'h80);
      queue_flush();

      while (byte_reqs.size() < 25 + RANDOM_REQS) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            queue_flush();
         end else if (pick < 22) begin
            queue_request(CMD_DATA, 8'($urandom_range(255)));
         end else begin
            seq = '0;
            if (pick < 40) begin
               // leads with a restricted second byte, either side of the limit
               case ($urandom_range(3))
                  0: seq[0] = LEAD3_LO;
                  1: seq[0] = LEAD_ED;
                  2: seq[0] = LEAD4_LO;
                  default: seq[0] = LEAD4_HI;
               endcase
               len = seq_len(seq[0]);
               for (int i = 1; i < 4; i++) seq[i] = 8'($urandom_range(8'h80, 8'hBF));
            end else begin
               len = $urandom_range(1, 4);
               case (len)
                  1: seq[0] = 8'($urandom_range(8'h7F));
                  2: begin
                     cp = CP_W'($urandom_range(12'h080, 12'h7FF));
                     seq[0] = {3'b110, cp[10:6]};
                     seq[1] = {2'b10, cp[5:0]};
                  end
                  3: begin
                     cp = {5'd0, 16'hD800};
                     while (cp[20:11] == SURR_TOP)
                        cp = CP_W'($urandom_range(16'h0800, 16'hFFFF));
                     seq[0] = {4'b1110, cp[15:12]};
                     seq[1] = {2'b10, cp[11:6]};
                     seq[2] = {2'b10, cp[5:0]};
                  end
                  default: begin
                     cp = CP_W'($urandom_range(21'h010000, MAX_CP));
                     seq[0] = {5'b11110, cp[20:18]};
                     seq[1] = {2'b10, cp[17:12]};
                     seq[2] = {2'b10, cp[11:6]};
                     seq[3] = {2'b10, cp[5:0]};
                  end
               endcase
               dmg = $urandom_range(9);
               if (len > 1 && dmg == 0) seq[$urandom_range(len - 1)] = 8'($urandom_range(255));
               if (len > 1 && dmg == 1) len = $urandom_range(1, len - 1);
            end
            for (int i = 0; i < len; i++) queue_request(CMD_DATA, seq[i]);
         end
      end
      total_reqs = byte_reqs.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted_reqs < total_reqs || pending_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d requests, %0d of them flushes, with random stalls on both sides",
               accepted_reqs, accepted_flushes);
      $display("Checked %0d decoded characters, %0d of them replacements",
               chars_seen, repl_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
